// ----- design/csvft_pkg.sv -----
// ----------------------------------------------------------------------------
// csvft_pkg
// Shared constants and types for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvft_pkg;

   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_VT     = 8'h0B;
   localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_EOI  = 1'b1;

   typedef enum logic {
      EMIT_IDLE,
      EMIT_BUSY
   } emit_state_type;

   // field hand-off from parser to emitter
   typedef struct packed {
      logic start;    // begin draining a field
      logic empty;    // field has no bytes: send one marker
      logic rec_end;  // field closes the record
      logic ovf;      // field lost bytes
   } emit_cmd_type;

endpackage

// ----- design/csvft_if.sv -----
// ----------------------------------------------------------------------------
// csvft_req_if / csvft_rsp_if
// Valid/ready channels for text input and field output.
// ----------------------------------------------------------------------------
interface csvft_req_if;
   logic                        valid;
   logic                        ready;
   logic [csvft_pkg::BYTE_W-1:0] data_byte;
   logic                        mode;

   modport source (output valid, output data_byte, output mode, input ready);
   modport sink   (input valid, input data_byte, input mode, output ready);
endinterface

interface csvft_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [csvft_pkg::BYTE_W-1:0] out_byte;
   logic                        byte_valid;
   logic                        field_end;
   logic                        record_end;
   logic                        field_overflow;

   modport source (output valid, output out_byte, output byte_valid, output field_end,
                   output record_end, output field_overflow, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input field_end,
                   input record_end, input field_overflow, output ready);
endinterface

// ----- design/csvft_ram.sv -----
// ----------------------------------------------------------------------------
// csvft_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module csvft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/csvft_parser.sv -----
// ----------------------------------------------------------------------------
// csvft_parser
// Per-byte tokenizer state; writes field bytes to the field RAM and hands
// finished fields to the emitter.
// ----------------------------------------------------------------------------
module csvft_parser #(
   parameter int FIELD_MAX = 64,
   parameter int LEN_W     = $clog2(FIELD_MAX + 1),
   parameter int IDX_W     = $clog2(FIELD_MAX)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [csvft_pkg::BYTE_W-1:0]  data_byte,
   input  logic                          mode,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output logic [csvft_pkg::BYTE_W-1:0]  wr_data,
   output logic [LEN_W-1:0]              emit_len,
   output csvft_pkg::emit_cmd_type       cmd
);
   import csvft_pkg::*;

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  untrim_ff, untrim_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic              inq_ff, inq_in;
   logic              qpend_ff, qpend_in;
   logic              quoted_ff, quoted_in;
   logic              path_ff, path_in;
   logic              recopen_ff, recopen_in;
   logic              ovf_ff, ovf_in;

   function automatic logic is_white(input logic [BYTE_W-1:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
             (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
   endfunction

   always_comb begin
      logic              do_append;
      logic              do_emit;
      logic              do_clear;
      logic              rec_end;
      logic              skip;
      logic [BYTE_W-1:0] app_byte;

      do_append  = 1'b0;
      do_emit    = 1'b0;
      do_clear   = 1'b0;
      rec_end    = 1'b0;
      skip       = 1'b0;
      app_byte   = data_byte;

      len_in     = len_ff;
      untrim_in  = untrim_ff;
      prev_in    = prev_ff;
      inq_in     = inq_ff;
      qpend_in   = qpend_ff;
      quoted_in  = quoted_ff;
      path_in    = path_ff;
      recopen_in = recopen_ff;
      ovf_in     = ovf_ff;

      wr_en    = 1'b0;
      wr_addr  = len_ff[IDX_W-1:0];
      wr_data  = app_byte;
      emit_len = (quoted_ff || path_ff) ? len_ff : untrim_ff;
      cmd      = '0;

      if (accept) begin
         if (mode == MODE_EOI) begin
            do_clear = 1'b1;
            if (recopen_ff || (len_ff != '0) || quoted_ff) begin
               do_emit = 1'b1;
               rec_end = 1'b1;
            end
         end else begin
            if (qpend_ff) begin
               qpend_in = 1'b0;
               if (data_byte == CH_QUOTE) begin
                  do_append = 1'b1;
                  skip      = 1'b1;
               end else begin
                  inq_in = 1'b0;
               end
            end
            if (!skip) begin
               unique case (data_byte) inside
                  CH_TAB, CH_SPACE: begin
                     if ((len_ff != '0) || inq_in || path_ff) begin
                        do_append = 1'b1;
                     end
                  end
                  CH_BSLASH: begin
                     if (len_ff == '0) begin
                        path_in = 1'b1;
                     end
                     do_append = 1'b1;
                  end
                  CH_QUOTE: begin
                     if (inq_in) begin
                        qpend_in = 1'b1;
                     end else if (len_ff == '0) begin
                        quoted_in = 1'b1;
                        inq_in    = 1'b1;
                     end else begin
                        do_append = 1'b1;
                     end
                  end
                  CH_COMMA, CH_LF: begin
                     if (inq_in) begin
                        do_append = 1'b1;
                     end else if (path_ff && (data_byte == CH_COMMA) && (len_ff != '0) &&
                                  (prev_ff != CH_BSLASH)) begin
                        do_append = 1'b1;
                     end else if ((data_byte == CH_LF) && !recopen_ff && (len_ff == '0) &&
                                  !quoted_ff) begin
                        do_clear = 1'b1;
                     end else begin
                        do_emit = 1'b1;
                        rec_end = (data_byte == CH_LF);
                     end
                  end
                  default: begin
                     do_append = 1'b1;
                  end
               endcase
            end
         end

         if (do_append) begin
            prev_in = app_byte;
            if (len_ff < LEN_W'(FIELD_MAX)) begin
               wr_en  = 1'b1;
               len_in = len_ff + 1'b1;
               if (!is_white(app_byte)) begin
                  untrim_in = len_ff + 1'b1;
               end
            end else begin
               ovf_in = 1'b1;
            end
         end

         if (do_emit) begin
            cmd.start   = 1'b1;
            cmd.empty   = (emit_len == '0);
            cmd.rec_end = rec_end;
            cmd.ovf     = ovf_ff;
            recopen_in  = !rec_end;
            do_clear    = 1'b1;
         end

         if (do_clear) begin
            len_in    = '0;
            untrim_in = '0;
            prev_in   = '0;
            inq_in    = 1'b0;
            qpend_in  = 1'b0;
            quoted_in = 1'b0;
            path_in   = 1'b0;
            ovf_in    = 1'b0;
         end

         if (mode == MODE_EOI) begin
            recopen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         untrim_ff  <= '0;
         prev_ff    <= '0;
         inq_ff     <= 1'b0;
         qpend_ff   <= 1'b0;
         quoted_ff  <= 1'b0;
         path_ff    <= 1'b0;
         recopen_ff <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         len_ff     <= len_in;
         untrim_ff  <= untrim_in;
         prev_ff    <= prev_in;
         inq_ff     <= inq_in;
         qpend_ff   <= qpend_in;
         quoted_ff  <= quoted_in;
         path_ff    <= path_in;
         recopen_ff <= recopen_in;
         ovf_ff     <= ovf_in;
      end
   end

`ifndef SYNTHESIS
   // trimmed length never runs past stored length
   a_untrim_le_len: assert property (@(posedge clock) disable iff (reset)
      untrim_ff <= len_ff)
      else $error("untrimmed end beyond field length");

   // a write only ever lands below the buffer size
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (len_ff < LEN_W'(FIELD_MAX)))
      else $error("field RAM write out of range");

   // a finished field leaves the field state cleared
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> ((len_ff == '0) && !quoted_ff && !path_ff && !ovf_ff))
      else $error("field state not cleared after emit");
`endif

endmodule

// ----- design/csvft_emitter.sv -----
// ----------------------------------------------------------------------------
// csvft_emitter
// Drains a finished field from the field RAM, one byte per transaction (an empty field sends one marker).
// ----------------------------------------------------------------------------
module csvft_emitter #(
   parameter int FIELD_MAX = 64,
   parameter int LEN_W     = $clog2(FIELD_MAX + 1),
   parameter int IDX_W     = $clog2(FIELD_MAX)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  csvft_pkg::emit_cmd_type       cmd,
   input  logic [LEN_W-1:0]              emit_len,
   input  logic [csvft_pkg::BYTE_W-1:0]  rd_data,
   output logic [IDX_W-1:0]              rd_addr,
   output logic                          busy,
   csvft_rsp_if.source                   rsp_bus
);
   import csvft_pkg::*;

   emit_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              empty_ff, empty_in;
   logic              rec_end_ff, rec_end_in;
   logic              ovf_ff, ovf_in;
   logic              fire;
   logic              last;

   assign fire = rsp_bus.valid && rsp_bus.ready;
   assign last = empty_ff || ((LEN_W'(out_idx_ff) + 1'b1) == len_ff);

   assign busy                   = (state_ff == EMIT_BUSY);
   assign rsp_bus.valid          = busy;
   assign rsp_bus.out_byte       = empty_ff ? '0 : rd_data;
   assign rsp_bus.byte_valid     = !empty_ff;
   assign rsp_bus.field_end      = last;
   assign rsp_bus.record_end     = last && rec_end_ff;
   assign rsp_bus.field_overflow = ovf_ff;

   always_comb begin
      state_in   = state_ff;
      out_idx_in = out_idx_ff;
      len_in     = len_ff;
      empty_in   = empty_ff;
      rec_end_in = rec_end_ff;
      ovf_in     = ovf_ff;
      rd_addr    = '0;

      unique case (state_ff)
         EMIT_IDLE: begin
            // address zero is already being read when a field starts
            if (cmd.start) begin
               state_in   = EMIT_BUSY;
               out_idx_in = '0;
               len_in     = emit_len;
               empty_in   = cmd.empty;
               rec_end_in = cmd.rec_end;
               ovf_in     = cmd.ovf;
            end
         end
         EMIT_BUSY: begin
            rd_addr = out_idx_ff;
            if (fire) begin
               rd_addr = IDX_W'(out_idx_ff + 1'b1);
               if (last) begin
                  state_in = EMIT_IDLE;
               end else begin
                  out_idx_in = IDX_W'(out_idx_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = EMIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= EMIT_IDLE;
         out_idx_ff <= '0;
         len_ff     <= '0;
         empty_ff   <= 1'b0;
         rec_end_ff <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_idx_ff <= out_idx_in;
         len_ff     <= len_in;
         empty_ff   <= empty_in;
         rec_end_ff <= rec_end_in;
         ovf_ff     <= ovf_in;
      end
   end

`ifndef SYNTHESIS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (state_ff == EMIT_IDLE))
      else $error("field handed over while emitter busy");

   a_last_ends_field: assert property (@(posedge clock) disable iff (reset)
      (fire && last) |=> !rsp_bus.valid)
      else $error("emitter still busy after last transaction");

   a_idx_in_field: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == EMIT_BUSY) && !empty_ff) |-> (LEN_W'(out_idx_ff) < len_ff))
      else $error("read index past field length");
`endif

endmodule

// ----- design/csv_field_tokenizer.sv -----
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// CSV text tokenizer: bytes in, field bytes with field/record markers out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                         | handshake
//  ---------+-----+-------------------------------------------------+-----------
//  req_bus  | in  | data_byte[7:0], mode (0 data, 1 end of input)    | valid/ready
//  rsp_bus  | out | out_byte[7:0], byte_valid, field_end,            | valid/ready
//           |     | record_end, field_overflow                       |
//
//  A byte that closes a field starts a drain of its emitted transactions
//  (a lone marker counts as one): req_bus.ready is low for the whole drain,
//  including any rsp_bus stall. The field RAM has a single read port and
//  delivers one stored byte per cycle, in the cycle after its address.
//  Reset is synchronous; it clears all parser and emitter control state.
//  Field RAM contents are not cleared; only entries below the stored length
//  are ever put on the output.
//  Output payload holds while rsp_bus.ready is low (the read address is held).
//
module csv_field_tokenizer #(
   parameter int FIELD_MAX = 64   // field buffer size, 8..64 bytes
) (
   input  logic        clock,
   input  logic        reset,
   csvft_req_if.sink   req_bus,
   csvft_rsp_if.source rsp_bus
);
   import csvft_pkg::*;

   localparam int LEN_W = $clog2(FIELD_MAX + 1);
   localparam int IDX_W = $clog2(FIELD_MAX);

   logic               busy;
   logic               accept;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [BYTE_W-1:0]  wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [BYTE_W-1:0]  rd_data;
   logic [LEN_W-1:0]   emit_len;
   emit_cmd_type       cmd;

   // input stalls for the whole drain of a field; the RAM is never
   // written while a field is read out
   assign req_bus.ready = !busy;
   assign accept        = req_bus.valid && req_bus.ready;

   csvft_parser #(
      .FIELD_MAX (FIELD_MAX)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_bus.data_byte),
      .mode      (req_bus.mode),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .emit_len  (emit_len),
      .cmd       (cmd)
   );

   // field buffer
   csvft_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FIELD_MAX)
   ) u_field_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   csvft_emitter #(
      .FIELD_MAX (FIELD_MAX)
   ) u_emitter (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .emit_len (emit_len),
      .rd_data  (rd_data),
      .rd_addr  (rd_addr),
      .busy     (busy),
      .rsp_bus  (rsp_bus)
   );

`ifndef SYNTHESIS
   // no input transaction while a field transaction is outstanding
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_bus.valid)
      else $error("input accepted during field emission");

   // RAM is never written during a drain
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy)
      else $error("field RAM written during emission");

   // a closed field shows up on the output the next cycle
   a_emit_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> rsp_bus.valid)
      else $error("field start without output");
`endif

endmodule
